[design/ambient_light_lux_autorange_assert.svh]
// assertion macros shared by the block
`ifndef AMBIENT_LIGHT_LUX_AUTORANGE_ASSERT_SVH
`define AMBIENT_LIGHT_LUX_AUTORANGE_ASSERT_SVH

// checked at every edge outside reset
`define ALLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ALLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/alla_pkg.sv]
`timescale 1ns / 1ps

package alla_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LIMIT_W  = 23;
  localparam int unsigned STEP_W   = 3;
  localparam int unsigned LUX_W    = 32;

  // number of integration time settings, index 0 is the 160 ms setting
  localparam logic [STEP_W:0] TIME_STEPS = 4'd6;

  // serial divider produces one quotient bit per cycle
  localparam int unsigned      DIV_STEPS = LIMIT_W;
  localparam logic [4:0]       DIV_LAST  = 5'(DIV_STEPS - 1);
  localparam logic [LIMIT_W-1:0] PERCENT = 23'd100;

  localparam logic [2:0] REG_RED_COEF_LOW    = 3'd0;
  localparam logic [2:0] REG_RED_COEF_HIGH   = 3'd1;
  localparam logic [2:0] REG_GREEN_COEF_LOW  = 3'd2;
  localparam logic [2:0] REG_GREEN_COEF_HIGH = 3'd3;
  localparam logic [2:0] REG_RATIO_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_BRIGHT_LIMIT    = 3'd5;
  localparam logic [2:0] REG_DIM_LIMIT       = 3'd6;
  localparam logic [2:0] REG_GAIN_CODE       = 3'd7;

  localparam logic [1:0] GAIN_1X  = 2'd0;
  localparam logic [1:0] GAIN_2X  = 2'd1;
  localparam logic [1:0] GAIN_16X = 2'd2;

  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_GREEN_ZERO    = 2'd1;
  localparam logic [1:0] STATUS_TIME_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] green_sample;
    logic [SAMPLE_W-1:0] clear_sample;
  } sample_t;

  typedef struct packed {
    logic [LUX_W-1:0]  lux_value;
    logic [1:0]        status_code;
    logic [STEP_W-1:0] time_setting;
    logic              time_changed;
  } result_t;

endpackage

[design/ambient_light_lux_autorange.sv]
// a sample transfer passes ST_DIV, ST_MUL_R, ST_MUL_G and ST_FIN, which registers the result;
// a zero green sample goes straight to ST_FIN; a new sample waits for idle, so the rate is set by the
//   one-bit-per-cycle divider for 100*clear/green, the shared 16x16 multiplier and result stalls in ST_FIN
// a new sample is taken while the previous result still waits to be taken
// reset: synchronous, clears control state, time index to 0, bright_limit to all ones
`timescale 1ns / 1ps
`include "ambient_light_lux_autorange_assert.svh"

module ambient_light_lux_autorange
  import alla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  sample_t             sample,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_MUL_R, ST_MUL_G, ST_FIN} state_t;

  state_t state;

  logic [SAMPLE_W-1:0] red_coef_low, red_coef_high, green_coef_low, green_coef_high;
  logic [LIMIT_W-1:0]  ratio_threshold, bright_limit, dim_limit;
  logic [1:0]          gain_code;

  logic [STEP_W-1:0]   time_step;
  logic                last_was_decrease;

  sample_t             smp;
  logic                green_zero;
  logic [LIMIT_W-1:0]  quo;
  logic [SAMPLE_W-1:0] rem;
  logic [4:0]          div_count;
  logic [32:0]         acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      red_coef_low    <= '0;
      red_coef_high   <= '0;
      green_coef_low  <= '0;
      green_coef_high <= '0;
      ratio_threshold <= '0;
      bright_limit    <= '1;
      dim_limit       <= '0;
      gain_code       <= GAIN_1X;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RED_COEF_LOW:    red_coef_low    <= cfg_data[SAMPLE_W-1:0];
        REG_RED_COEF_HIGH:   red_coef_high   <= cfg_data[SAMPLE_W-1:0];
        REG_GREEN_COEF_LOW:  green_coef_low  <= cfg_data[SAMPLE_W-1:0];
        REG_GREEN_COEF_HIGH: green_coef_high <= cfg_data[SAMPLE_W-1:0];
        REG_RATIO_THRESHOLD: ratio_threshold <= cfg_data;
        REG_BRIGHT_LIMIT:    bright_limit    <= cfg_data;
        REG_DIM_LIMIT:       dim_limit       <= cfg_data;
        REG_GAIN_CODE:       gain_code       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign sample_stall = (state != ST_IDLE);

  logic sample_xfer, result_xfer, result_free;
  assign sample_xfer = sample_valid && !sample_stall;
  assign result_xfer = result_valid && !result_stall;
  assign result_free = !result_valid || !result_stall;

  // restoring divider step
  logic [SAMPLE_W:0]   trial, trial_diff;
  logic                trial_ge;
  assign trial      = {rem, quo[LIMIT_W-1]};
  assign trial_ge   = trial >= {1'b0, smp.green_sample};
  assign trial_diff = trial - {1'b0, smp.green_sample};

  logic [LIMIT_W-1:0] clear_pct;
  assign clear_pct = {7'd0, sample.clear_sample} * PERCENT;

  // shared multiplier, red term then green term
  logic                low_ratio;
  logic [SAMPLE_W-1:0] mul_coef, mul_smp;
  logic [31:0]         product;
  assign low_ratio = quo < ratio_threshold;
  always_comb begin
    if (state == ST_MUL_R) begin
      mul_coef = low_ratio ? red_coef_low : red_coef_high;
      mul_smp  = smp.red_sample;
    end else begin
      mul_coef = low_ratio ? green_coef_low : green_coef_high;
      mul_smp  = smp.green_sample;
    end
  end
  assign product = mul_coef * mul_smp;

  // lux = weighted*2560/gain/(160 << step) reduces to (weighted*16) >> (log2 gain + step)
  logic [2:0]  gain_shift;
  logic [3:0]  shamt;
  logic [36:0] scaled;
  logic [LUX_W-1:0] lux;
  always_comb begin
    case (gain_code)
      GAIN_1X: gain_shift = 3'd0;
      GAIN_2X: gain_shift = 3'd1;
      default: gain_shift = 3'd4;
    endcase
  end
  assign shamt  = {1'b0, gain_shift} + {1'b0, time_step};
  assign scaled = {acc, 4'b0000} >> shamt;
  assign lux    = (|scaled[36:32]) ? '1 : scaled[LUX_W-1:0];

  // auto-ranging with hysteresis
  logic [LIMIT_W-1:0] red_pct, green_pct;
  logic               bright, dim;
  logic [STEP_W:0]    step_inc;
  logic [STEP_W-1:0]  step_next;
  logic               dec_next;
  logic [1:0]         status_next;
  assign red_pct   = {7'd0, smp.red_sample} * PERCENT;
  assign green_pct = {7'd0, smp.green_sample} * PERCENT;
  assign bright    = (red_pct > bright_limit) || (green_pct > bright_limit);
  assign dim       = (red_pct < dim_limit) || (green_pct < dim_limit);
  assign step_inc  = {1'b0, time_step} + 1'b1;

  always_comb begin
    step_next   = time_step;
    dec_next    = last_was_decrease;
    status_next = STATUS_OK;
    if (bright && (time_step != '0)) begin
      step_next = time_step - 1'b1;
      dec_next  = 1'b1;
    end else if (dim && last_was_decrease) begin
      dec_next = 1'b0;
      if (step_inc >= TIME_STEPS) status_next = STATUS_TIME_OVERFLOW;
      else                        step_next   = step_inc[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      time_step         <= '0;
      last_was_decrease <= 1'b1;
      result_valid      <= 1'b0;
      div_count         <= '0;
    end else begin
      // in fin a transfer is followed by the next result in the same cycle
      if (result_xfer && (state != ST_FIN)) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (sample_xfer) begin
            smp        <= sample;
            green_zero <= (sample.green_sample == '0);
            quo        <= clear_pct;
            rem        <= '0;
            div_count  <= '0;
            state      <= (sample.green_sample == '0) ? ST_FIN : ST_DIV;
          end
        end
        ST_DIV: begin
          quo <= {quo[LIMIT_W-2:0], trial_ge};
          rem <= trial_ge ? trial_diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
          div_count <= div_count + 1'b1;
          if (div_count == DIV_LAST) state <= ST_MUL_R;
        end
        ST_MUL_R: begin
          acc   <= {1'b0, product};
          state <= ST_MUL_G;
        end
        ST_MUL_G: begin
          acc   <= acc + {1'b0, product};
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (result_free) begin
            result_valid <= 1'b1;
            if (green_zero) begin
              result.lux_value    <= '0;
              result.status_code  <= STATUS_GREEN_ZERO;
              result.time_setting <= time_step;
              result.time_changed <= 1'b0;
            end else begin
              result.lux_value    <= lux;
              result.status_code  <= status_next;
              result.time_setting <= step_next;
              result.time_changed <= (step_next != time_step);
              time_step           <= step_next;
              last_was_decrease   <= dec_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ALLA_ASSERT(a_step_range, (time_step < TIME_STEPS[STEP_W-1:0] || TIME_STEPS[STEP_W]), "time index out of range")
  `ALLA_ASSERT(a_result_tracks_step, result_valid |-> result.time_setting == time_step, "held result disagrees with time index")
  `ALLA_ASSERT(a_overflow_no_change, (result_valid && result.status_code == STATUS_TIME_OVERFLOW) |-> !result.time_changed, "overflow result changed index")
  `ALLA_ASSERT(a_green_zero_result, (result_valid && result.status_code == STATUS_GREEN_ZERO) |-> (result.lux_value == '0 && !result.time_changed), "green zero result not clean")
  `ALLA_ASSERT(a_div_bound, (state == ST_DIV) |-> (div_count <= DIV_LAST), "divider ran past its last step")

endmodule
